// ----- rtl/stn_pkg.sv -----
// ----------------------------------------------------------------------------
// stn_pkg: shared types and constants
// Coordinate widths, queue entry and channel request types for the
// segment/triangle nearest-hit core.
// ----------------------------------------------------------------------------
package stn_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int T_FRAC_BITS = 16;
  localparam int T_W         = T_FRAC_BITS + 1;
  // edge vectors carry one extra bit
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // triple products grow to 3*DIFF_W+3 bits; keep headroom
  localparam int WIDE_W      = 3 * DIFF_W + 6;
  localparam int CFG_AW      = 3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_END_Z   = 3'd5;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;

  typedef struct packed {
    coord_t vert_a_x;
    coord_t vert_a_y;
    coord_t vert_a_z;
    coord_t vert_b_x;
    coord_t vert_b_y;
    coord_t vert_b_z;
    coord_t vert_c_x;
    coord_t vert_c_y;
    coord_t vert_c_z;
    logic   last_triangle;
  } in_req_t;

  typedef struct packed {
    logic           tri_hit;
    logic [T_W-1:0] tri_t;
    logic [T_W-1:0] nearest_t;
    logic           any_hit;
    logic           ray_done;
  } out_rsp_t;

  // edge vectors handed from front to back
  typedef struct packed {
    diff_t ab_x, ab_y, ab_z;
    diff_t ac_x, ac_y, ac_z;
    diff_t qp_x, qp_y, qp_z;
    diff_t ap_x, ap_y, ap_z;
    logic  last;
  } tri_job_t;

  function automatic diff_t coord_sub(input coord_t a, input coord_t b);
    return diff_t'({a[COORD_WIDTH-1], a}) - diff_t'({b[COORD_WIDTH-1], b});
  endfunction

endpackage

// ----- rtl/stn_front.sv -----
// ----------------------------------------------------------------------------
// stn_front: configuration and edge setup
// Holds the segment endpoints and turns each triangle request into its
// edge vectors for the job queue.
// ----------------------------------------------------------------------------
module stn_front import stn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata,
  input  in_req_t           req,
  output tri_job_t          job
);

  coord_t sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;

  // segment endpoint registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      ex_r <= '0; ey_r <= '0; ez_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_X: sx_r <= coord_t'(cfg_wdata);
        REG_START_Y: sy_r <= coord_t'(cfg_wdata);
        REG_START_Z: sz_r <= coord_t'(cfg_wdata);
        REG_END_X:   ex_r <= coord_t'(cfg_wdata);
        REG_END_Y:   ey_r <= coord_t'(cfg_wdata);
        REG_END_Z:   ez_r <= coord_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // edge vectors, exact in DIFF_W bits
  always_comb begin
    job.ab_x = coord_sub(req.vert_b_x, req.vert_a_x);
    job.ab_y = coord_sub(req.vert_b_y, req.vert_a_y);
    job.ab_z = coord_sub(req.vert_b_z, req.vert_a_z);
    job.ac_x = coord_sub(req.vert_c_x, req.vert_a_x);
    job.ac_y = coord_sub(req.vert_c_y, req.vert_a_y);
    job.ac_z = coord_sub(req.vert_c_z, req.vert_a_z);
    job.qp_x = coord_sub(sx_r, ex_r);
    job.qp_y = coord_sub(sy_r, ey_r);
    job.qp_z = coord_sub(sz_r, ez_r);
    job.ap_x = coord_sub(sx_r, req.vert_a_x);
    job.ap_y = coord_sub(sy_r, req.vert_a_y);
    job.ap_z = coord_sub(sz_r, req.vert_a_z);
    job.last = req.last_triangle;
  end

endmodule

// ----- rtl/stn_fifo.sv -----
// ----------------------------------------------------------------------------
// stn_fifo: two-entry job queue
// Decouples triangle intake from the arithmetic back end.
// ----------------------------------------------------------------------------
module stn_fifo import stn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tri_job_t wdata,
  output logic     full,
  input  logic     pop,
  output tri_job_t rdata,
  output logic     empty
);

  tri_job_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/stn_back.sv -----
// ----------------------------------------------------------------------------
// stn_back: intersection sequencer
// Runs the cross and dot products on one shift-add multiplier, tests the
// barycentric bounds, divides t by d bit by bit and keeps the nearest hit.
// ----------------------------------------------------------------------------
module stn_back import stn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tri_job_t job,
  input  logic     job_empty,
  output logic     job_pop,
  output out_rsp_t rsp,
  output logic     rsp_empty,
  input  logic     rsp_pop
);

  localparam int OPS   = 24;
  localparam int OP_W  = $clog2(OPS);
  localparam int BIT_W = $clog2(DIFF_W);
  localparam int DIV_W = $clog2(T_W);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_TEST, S_DIV, S_FIN} state_t;

  state_t          state_r;
  tri_job_t        cur_r;
  logic [OP_W-1:0] op_r;
  logic [BIT_W-1:0] bit_r;
  logic [DIV_W-1:0] div_r;
  diff_t           mplier_r;
  wide_t           mcand_r, acc_r;
  wide_t           n0_r, n1_r, n2_r, e0_r, e1_r, e2_r, d_r, t_r, v_r, w_r;
  logic [WIDE_W-1:0] rem_r;
  logic [T_W-1:0]  q_r, near_r;
  logic            hit_r, seen_r, out_valid_r;
  out_rsp_t        out_r;

  diff_t  op_a;
  wide_t  op_b, acc_add, mterm;
  logic   op_sub, grp_start, neg;
  logic [WIDE_W-1:0] rr, rsub;
  logic   ge, hit_c;
  logic [T_W-1:0] near_upd;
  logic   rsp_load;

  function automatic wide_t sx(input diff_t v);
    return wide_t'(v);
  endfunction

  // operand schedule of the multiply-accumulate program
  always_comb begin
    op_a = cur_r.ab_y; op_b = sx(cur_r.ac_z); op_sub = 1'b0;
    case (op_r)
      5'd0:  begin op_a = cur_r.ab_y; op_b = sx(cur_r.ac_z); end
      5'd1:  begin op_a = cur_r.ab_z; op_b = sx(cur_r.ac_y); op_sub = 1'b1; end
      5'd2:  begin op_a = cur_r.ab_z; op_b = sx(cur_r.ac_x); end
      5'd3:  begin op_a = cur_r.ab_x; op_b = sx(cur_r.ac_z); op_sub = 1'b1; end
      5'd4:  begin op_a = cur_r.ab_x; op_b = sx(cur_r.ac_y); end
      5'd5:  begin op_a = cur_r.ab_y; op_b = sx(cur_r.ac_x); op_sub = 1'b1; end
      5'd6:  begin op_a = cur_r.qp_x; op_b = n0_r; end
      5'd7:  begin op_a = cur_r.qp_y; op_b = n1_r; end
      5'd8:  begin op_a = cur_r.qp_z; op_b = n2_r; end
      5'd9:  begin op_a = cur_r.ap_x; op_b = n0_r; end
      5'd10: begin op_a = cur_r.ap_y; op_b = n1_r; end
      5'd11: begin op_a = cur_r.ap_z; op_b = n2_r; end
      5'd12: begin op_a = cur_r.qp_y; op_b = sx(cur_r.ap_z); end
      5'd13: begin op_a = cur_r.qp_z; op_b = sx(cur_r.ap_y); op_sub = 1'b1; end
      5'd14: begin op_a = cur_r.qp_z; op_b = sx(cur_r.ap_x); end
      5'd15: begin op_a = cur_r.qp_x; op_b = sx(cur_r.ap_z); op_sub = 1'b1; end
      5'd16: begin op_a = cur_r.qp_x; op_b = sx(cur_r.ap_y); end
      5'd17: begin op_a = cur_r.qp_y; op_b = sx(cur_r.ap_x); op_sub = 1'b1; end
      5'd18: begin op_a = cur_r.ac_x; op_b = e0_r; end
      5'd19: begin op_a = cur_r.ac_y; op_b = e1_r; end
      5'd20: begin op_a = cur_r.ac_z; op_b = e2_r; end
      5'd21: begin op_a = cur_r.ab_x; op_b = e0_r; op_sub = 1'b1; end
      5'd22: begin op_a = cur_r.ab_y; op_b = e1_r; op_sub = 1'b1; end
      5'd23: begin op_a = cur_r.ab_z; op_b = e2_r; op_sub = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    case (op_r)
      5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12, 5'd14, 5'd16, 5'd18, 5'd21:
        grp_start = 1'b1;
      default: grp_start = 1'b0;
    endcase
  end

  // one shift-add step; the sign bit of the multiplier weighs negative
  assign neg     = op_sub ^ (bit_r == BIT_W'(DIFF_W - 1));
  assign mterm   = mplier_r[0] ? mcand_r : '0;
  assign acc_add = neg ? acc_r - mterm : acc_r + mterm;

  // restoring divide step
  assign rr   = (div_r == '0) ? rem_r : {rem_r[WIDE_W-2:0], 1'b0};
  assign ge   = (rr >= d_r);
  assign rsub = rr - d_r;

  // hit tests
  assign hit_c = (d_r > 0) && (t_r >= 0) && (t_r <= d_r) && (v_r >= 0) &&
                 (v_r <= d_r) && (w_r >= 0) && ((v_r + w_r) <= d_r);

  assign near_upd = (hit_r && (q_r < near_r)) ? q_r : near_r;

  // result register takes a new value when it is free or being popped
  assign rsp_load  = (state_r == S_FIN) && (!out_valid_r || rsp_pop);

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign rsp       = out_r;
  assign rsp_empty = !out_valid_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      near_r      <= T_W'(1) << T_FRAC_BITS;
      seen_r      <= 1'b0;
    end else begin
      if (rsp_load) out_valid_r <= 1'b1;
      else if (rsp_pop && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!job_empty) begin
            cur_r   <= job;
            op_r    <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          mplier_r <= op_a;
          mcand_r  <= op_b;
          bit_r    <= '0;
          if (grp_start) acc_r <= '0;
          state_r  <= S_MUL;
        end
        S_MUL: begin
          acc_r    <= acc_add;
          mcand_r  <= {mcand_r[WIDE_W-2:0], 1'b0};
          mplier_r <= mplier_r >>> 1;
          bit_r    <= bit_r + 1'b1;
          if (bit_r == BIT_W'(DIFF_W - 1)) begin
            case (op_r)
              5'd1:  n0_r <= acc_add;
              5'd3:  n1_r <= acc_add;
              5'd5:  n2_r <= acc_add;
              5'd8:  d_r  <= acc_add;
              5'd11: t_r  <= acc_add;
              5'd13: e0_r <= acc_add;
              5'd15: e1_r <= acc_add;
              5'd17: e2_r <= acc_add;
              5'd20: v_r  <= acc_add;
              5'd23: w_r  <= acc_add;
              default: ;
            endcase
            if (op_r == OP_W'(OPS - 1)) begin
              state_r <= S_TEST;
            end else begin
              op_r    <= op_r + 1'b1;
              state_r <= S_LOAD;
            end
          end
        end
        S_TEST: begin
          hit_r <= hit_c;
          q_r   <= '0;
          rem_r <= t_r;
          div_r <= '0;
          state_r <= hit_c ? S_DIV : S_FIN;
        end
        S_DIV: begin
          rem_r <= ge ? rsub : rr;
          q_r   <= {q_r[T_W-2:0], ge};
          div_r <= div_r + 1'b1;
          if (div_r == DIV_W'(T_W - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (rsp_load) begin
            out_r.tri_hit   <= hit_r;
            out_r.tri_t     <= q_r;
            out_r.nearest_t <= near_upd;
            out_r.any_hit   <= seen_r | hit_r;
            out_r.ray_done  <= cur_r.last;
            if (cur_r.last) begin
              near_r <= T_W'(1) << T_FRAC_BITS;
              seen_r <= 1'b0;
            end else begin
              near_r <= near_upd;
              seen_r <= seen_r | hit_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/segment_triangle_nearest_hit_core.sv -----
// ----------------------------------------------------------------------------
// segment_triangle_nearest_hit_core: segment vs. triangle nearest hit
// Write the segment endpoints S and E through cfg_we/cfg_addr/cfg_wdata
// while idle (indexes 0..2 start x/y/z, 3..5 end x/y/z; others ignored).
// Triangle requests enter on in_push/in_full, one triangle per request.
// Each request yields one result on out_empty/out_pop: the hit flag and
// Q1.16 t for that triangle, the nearest t of the current set (1.0 while
// none) and the any-hit flag; a request marked last_triangle closes the set.
// A request passes these steps in order: the back end picks it from the
// queue, runs 24 multiply-accumulate operations on one shared shift-add
// multiplier, tests the barycentric bounds, runs a restoring divide on hits
// and writes the result register. The back end takes no new triangle until
// it has written the result of the current one; a two-entry queue takes
// requests while the back end works.
// Reset clears the queue, the result register, the endpoints and the
// nearest-hit state. While the receiver stalls, the finished result holds
// and the back end waits before writing the next one.
// ----------------------------------------------------------------------------
module segment_triangle_nearest_hit_core import stn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_push,
  input  in_req_t           in_req,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output out_rsp_t          out_rsp
);

  tri_job_t front_job, q_job;
  logic     q_empty, q_pop;

  stn_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .req (in_req),
    .job (front_job)
  );

  stn_fifo u_fifo (
    .clk, .rst_n,
    .push  (in_push),
    .wdata (front_job),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_job),
    .empty (q_empty)
  );

  stn_back u_back (
    .clk, .rst_n,
    .job       (q_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .rsp       (out_rsp),
    .rsp_empty (out_empty),
    .rsp_pop   (out_pop)
  );

endmodule
